// ===== rtl/wtfu_pkg.sv =====
// ----------------------------------------------------------------------------
// wtfu_pkg
// Types, constants and helper functions of the WTF-8 form-urlencoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wtfu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // one scalar to encode, or one error marker
  typedef struct packed {
    logic [20:0] scalar;
    logic        last;
    logic        err;
  } entry_t;

  localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [20:0] HIGH_SURR_LO = 21'h00D800;
  localparam logic [20:0] HIGH_SURR_HI = 21'h00DBFF;
  localparam logic [20:0] LOW_SURR_LO  = 21'h00DC00;
  localparam logic [20:0] LOW_SURR_HI  = 21'h00DFFF;
  localparam logic [6:0]  CHAR_PLUS    = 7'h2B;
  localparam logic [6:0]  CHAR_PERCENT = 7'h25;
  localparam logic [7:0]  BYTE_SPACE   = 8'h20;

  // UTF-8 length minus one
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] v);
    logic [1:0] n;
    if (v[20:7] == 14'd0) begin
      n = 2'd0;
    end else if (v[20:11] == 10'd0) begin
      n = 2'd1;
    end else if (v[20:16] == 5'd0) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] v, input logic [1:0] nm1,
                                           input logic [1:0] k);
    logic [7:0] r;
    case (nm1)
      2'd0: r = v[7:0];
      2'd1: r = (k == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      2'd2: begin
        case (k)
          2'd0:    r = {4'b1110, v[15:12]};
          2'd1:    r = {2'b10, v[11:6]};
          default: r = {2'b10, v[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    r = {5'b11110, v[20:18]};
          2'd1:    r = {2'b10, v[17:12]};
          2'd2:    r = {2'b10, v[11:6]};
          default: r = {2'b10, v[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic is_safe(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) ||
           b == 8'h2A || b == 8'h2D || b == 8'h2E || b == 8'h5F;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (7'h30 + {3'b000, d}) : (7'h37 + {3'b000, d});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wtfu_front.sv =====
// ----------------------------------------------------------------------------
// wtfu_front
// Validates and decodes WTF-8 bytes, pairs surrogates and issues scalar
// entries (at most two per byte) to the entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wtfu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire wtfu_pkg::in_item_t byte_item,
  output logic                   push,
  output wtfu_pkg::entry_t       push_data,
  input  wire logic              full
);

  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic [9:0]  pending_high, pending_high_next;
  logic        pending_valid, pending_valid_next;
  logic        discarding, discarding_next;
  logic        hold_valid, hold_valid_next;
  wtfu_pkg::entry_t hold, hold_next;

  logic [7:0]  b;
  logic        last, take, cont, has_v, err;
  logic [20:0] v, accum_n;
  logic [1:0]  bl_n;
  logic [7:0]  lead_n;
  logic        is_hi, is_lo, ent_a, ent_b, ent_c, pend_after;
  logic [1:0]  cnt;
  wtfu_pkg::entry_t e_a, e_b, e_c, first, second;

  assign b          = byte_item.in_byte;
  assign last       = byte_item.in_last;
  assign cont       = (b[7:6] == 2'b10);
  assign byte_ready = !hold_valid && !full;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    has_v   = 1'b0;
    v       = '0;
    err     = 1'b0;
    accum_n = code_accum;
    bl_n    = bytes_left;
    lead_n  = lead_byte;
    if (bytes_left == 2'd0) begin
      if (b < 8'h80) begin
        has_v = 1'b1;
        v     = {13'd0, b};
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        accum_n = {16'd0, b[4:0]};
        bl_n    = 2'd1;
        lead_n  = b;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        accum_n = {17'd0, b[3:0]};
        bl_n    = 2'd2;
        lead_n  = b;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        accum_n = {18'd0, b[2:0]};
        bl_n    = 2'd3;
        lead_n  = b;
      end else begin
        err = 1'b1;
      end
    end else if (!cont) begin
      err = 1'b1;
    end else if ((lead_byte == 8'hE0 && bytes_left == 2'd2 && b < 8'hA0) ||
                 (lead_byte == 8'hF0 && bytes_left == 2'd3 && b < 8'h90) ||
                 (lead_byte == 8'hF4 && bytes_left == 2'd3 && b >= 8'h90)) begin
      err = 1'b1;
    end else begin
      accum_n = {code_accum[14:0], b[5:0]};
      bl_n    = bytes_left - 2'd1;
      if (bl_n == 2'd0) begin
        has_v   = 1'b1;
        v       = accum_n;
        accum_n = '0;
        lead_n  = '0;
      end
    end
    if (last && !err && bl_n != 2'd0) begin
      err = 1'b1;
    end
  end

  always_comb begin
    is_hi      = has_v && v >= wtfu_pkg::HIGH_SURR_LO && v <= wtfu_pkg::HIGH_SURR_HI;
    is_lo      = has_v && v >= wtfu_pkg::LOW_SURR_LO && v <= wtfu_pkg::LOW_SURR_HI;
    pend_after = is_hi ? 1'b1 : (has_v ? 1'b0 : pending_valid);
    ent_a      = has_v && pending_valid && !is_lo;
    ent_b      = has_v && !is_hi;
    ent_c      = last && pend_after;
    e_a        = '{scalar: wtfu_pkg::REPLACEMENT, last: 1'b0, err: 1'b0};
    e_c        = '{scalar: wtfu_pkg::REPLACEMENT, last: last, err: 1'b0};
    e_b.last   = last;
    e_b.err    = 1'b0;
    if (is_lo) begin
      e_b.scalar = pending_valid
                 ? wtfu_pkg::SUPP_BASE + {1'b0, pending_high, v[9:0]}
                 : wtfu_pkg::REPLACEMENT;
    end else begin
      e_b.scalar = v;
    end
    if (ent_a && !ent_b && !ent_c) begin
      e_a.last = last;
    end
    if (discarding) begin
      cnt    = 2'd0;
      first  = e_a;
      second = e_b;
    end else if (err) begin
      cnt    = 2'd1;
      first  = '{scalar: '0, last: 1'b1, err: 1'b1};
      second = e_b;
    end else begin
      cnt    = 2'({1'b0, ent_a} + {1'b0, ent_b} + {1'b0, ent_c});
      first  = ent_a ? e_a : (ent_b ? e_b : e_c);
      second = ent_b ? e_b : e_c;
    end
  end

  always_comb begin
    push      = (hold_valid && !full) || (take && cnt != 2'd0);
    push_data = hold_valid ? hold : first;
    hold_next = hold;
    hold_valid_next = hold_valid;
    if (hold_valid && !full) begin
      hold_valid_next = 1'b0;
    end
    if (take && cnt == 2'd2) begin
      hold_valid_next = 1'b1;
      hold_next       = second;
    end
  end

  always_comb begin
    code_accum_next    = code_accum;
    bytes_left_next    = bytes_left;
    lead_byte_next     = lead_byte;
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    discarding_next    = discarding;
    if (take) begin
      if (discarding) begin
        if (last) begin
          discarding_next = 1'b0;
        end
      end else if (err || last) begin
        code_accum_next    = '0;
        bytes_left_next    = '0;
        lead_byte_next     = '0;
        pending_high_next  = '0;
        pending_valid_next = 1'b0;
        discarding_next    = err && !last;
      end else begin
        code_accum_next = accum_n;
        bytes_left_next = bl_n;
        lead_byte_next  = lead_n;
        if (is_hi) begin
          pending_valid_next = 1'b1;
          pending_high_next  = v[9:0];
        end else if (has_v) begin
          pending_valid_next = 1'b0;
          pending_high_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum    <= '0;
      bytes_left    <= '0;
      lead_byte     <= '0;
      pending_high  <= '0;
      pending_valid <= 1'b0;
      discarding    <= 1'b0;
      hold_valid    <= 1'b0;
    end else begin
      code_accum    <= code_accum_next;
      bytes_left    <= bytes_left_next;
      lead_byte     <= lead_byte_next;
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      discarding    <= discarding_next;
      hold_valid    <= hold_valid_next;
    end
    hold <= hold_next;
  end

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> !byte_ready)
    else $error("input taken while a second entry is held");

  a_discard_clean: assert property (@(posedge clk) disable iff (rst)
    discarding |-> bytes_left == 2'd0 && !pending_valid)
    else $error("decode state left over while discarding");

endmodule

`default_nettype wire

// ===== rtl/wtfu_queue.sv =====
// ----------------------------------------------------------------------------
// wtfu_queue
// Short FIFO of scalar entries between the decoder and the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module wtfu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wtfu_pkg::entry_t push_data,
  output logic                  full,
  output logic                  head_valid,
  output wtfu_pkg::entry_t      head,
  input  wire logic             pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  wtfu_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("entry popped from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/wtfu_back.sv =====
// ----------------------------------------------------------------------------
// wtfu_back
// Re-encodes each scalar entry as UTF-8 and emits its form-urlencoded
// characters through an output register; an error marker emits one zero character.
// ----------------------------------------------------------------------------
`default_nettype none

module wtfu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire wtfu_pkg::entry_t  head,
  output logic                   pop,
  output logic                   char_valid,
  input  wire logic              char_ready,
  output wtfu_pkg::out_item_t    char_item
);

  logic [1:0] byte_idx, byte_idx_next;
  logic [1:0] char_idx, char_idx_next;
  logic       char_valid_next;
  wtfu_pkg::out_item_t char_item_next;

  logic [1:0] nm1;
  logic [7:0] ub;
  logic       safe, space, byte_done, ent_done, advance;
  logic [6:0] ch;

  assign nm1       = wtfu_pkg::utf8_len_m1(head.scalar);
  assign ub        = wtfu_pkg::utf8_byte(head.scalar, nm1, byte_idx);
  assign safe      = wtfu_pkg::is_safe(ub);
  assign space     = (ub == wtfu_pkg::BYTE_SPACE);
  assign byte_done = head.err || safe || space || char_idx == 2'd2;
  assign ent_done  = byte_done && (head.err || byte_idx == nm1);
  assign advance   = head_valid && (!char_valid || char_ready);
  assign pop       = advance && ent_done;

  always_comb begin
    if (head.err) begin
      ch = '0;
    end else if (safe) begin
      ch = ub[6:0];
    end else if (space) begin
      ch = wtfu_pkg::CHAR_PLUS;
    end else begin
      case (char_idx)
        2'd0:    ch = wtfu_pkg::CHAR_PERCENT;
        2'd1:    ch = wtfu_pkg::hex_char(ub[7:4]);
        default: ch = wtfu_pkg::hex_char(ub[3:0]);
      endcase
    end
  end

  always_comb begin
    byte_idx_next   = byte_idx;
    char_idx_next   = char_idx;
    char_item_next  = char_item;
    char_valid_next = char_ready ? 1'b0 : char_valid;
    if (advance) begin
      char_valid_next          = 1'b1;
      char_item_next.out_char  = ch;
      char_item_next.out_last  = head.last && ent_done;
      char_item_next.out_error = head.err;
      if (ent_done) begin
        byte_idx_next = '0;
        char_idx_next = '0;
      end else if (byte_done) begin
        byte_idx_next = byte_idx + 2'd1;
        char_idx_next = '0;
      end else begin
        char_idx_next = char_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx   <= '0;
      char_idx   <= '0;
      char_valid <= 1'b0;
    end else begin
      byte_idx   <= byte_idx_next;
      char_idx   <= char_idx_next;
      char_valid <= char_valid_next;
    end
    char_item <= char_item_next;
  end

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_item.out_error |-> char_item.out_last && char_item.out_char == 7'd0)
    else $error("error result not marked last or not zero");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> byte_idx <= nm1)
    else $error("byte index past the end of the UTF-8 sequence");

endmodule

`default_nettype wire

// ===== rtl/wtf8_to_form_urlencoder.sv =====
// ----------------------------------------------------------------------------
// wtf8_to_form_urlencoder
// Streaming WTF-8 validator and form-urlencoder: decode, pair surrogates,
// re-encode as UTF-8, turn a space into '+' and percent-escape every other unsafe byte.
//
//   channel  ports                               payload
//   input    byte_valid / byte_ready / byte_item  in_byte, in_last
//   output   char_valid / char_ready / char_item  out_char, out_last, out_error
//
// The decoder takes one byte per cycle when no held entry or full queue stalls
// it and posts up to two scalar entries; a byte that yields two holds the input
// until the second is pushed. The encoder emits one character per cycle while
// the output is ready: a safe byte gives one, a space '+', an escaped byte three.
// Throughput is set by the encoder; the entry queue absorbs bursts. Reset
// clears all decode state; no clearing pass. Either side may stall.
// ----------------------------------------------------------------------------
`default_nettype none

module wtf8_to_form_urlencoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire wtfu_pkg::in_item_t  byte_item,
  output logic                     char_valid,
  input  wire logic                char_ready,
  output wtfu_pkg::out_item_t      char_item
);

  logic             push, full, head_valid, pop;
  wtfu_pkg::entry_t push_data, head;

  wtfu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  wtfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  wtfu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

endmodule

`default_nettype wire
